>>> src/cdcpe_pkg.sv
// Package: types, constants and helper functions of the CD-ROM command packet engine.
package cdcpe_pkg;

	localparam int PACKET_BYTES = 8;
	localparam int IDX_W        = $clog2(PACKET_BYTES);
	localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
	localparam int LEN_W        = 3;
	localparam int ADDR_W       = 20;
	localparam int COEF_W       = 13;
	localparam int BCD_W        = 8;

	localparam logic [7:0] STATUS_VALUE = 8'h40;
	localparam logic [7:0] PHASE_VALUE  = 8'h0B;

	localparam logic [7:0] OP_SEEK    = 8'h50;
	localparam logic [7:0] OP_GETINFO = 8'h70;
	localparam logic [7:0] OP_PARAM   = 8'h90;
	localparam logic [7:0] OP_XFER    = 8'h10;
	localparam logic [7:0] OP_XFER2   = 8'hDC;
	localparam logic [7:0] OP_READ    = 8'hC0;
	localparam logic [7:0] OP_EXT     = 8'hFE;

	localparam logic [1:0] REG_STATUS = 2'd0;

	localparam logic [IDX_W-1:0] IDX_OPCODE = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_MIN    = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_SEC    = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_FRM    = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_COUNT  = IDX_W'(6);

	localparam logic [ADDR_W-1:0] LEAD_IN  = ADDR_W'(150);
	localparam logic [COEF_W-1:0] COEF_MIN = COEF_W'(60 * 75);
	localparam logic [COEF_W-1:0] COEF_SEC = COEF_W'(75);
	localparam logic [COEF_W-1:0] COEF_FRM = COEF_W'(1);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_RECEIVE = 3'd1,
		MODE_STATUS  = 3'd2,
		MODE_DATAOUT = 3'd3,
		MODE_READ    = 3'd4,
		MODE_ERROR   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_FETCH,
		SEQ_MIN,
		SEQ_SEC,
		SEQ_FRM,
		SEQ_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		COEF_SEL_MIN,
		COEF_SEL_SEC,
		COEF_SEL_FRM
	} coef_sel_t;

	typedef struct packed {
		logic      load;
		logic      accum;
		coef_sel_t coef;
	} addr_ctl_t;

	function automatic logic [LEN_W-1:0] length_for(input logic [7:0] op);
		logic [LEN_W-1:0] len;
		unique case (op)
			OP_SEEK:  len = LEN_W'(2);
			OP_PARAM: len = LEN_W'(3);
			OP_READ:  len = LEN_W'(7);
			OP_EXT:   len = LEN_W'(2);
			default:  len = LEN_W'(1);
		endcase
		return len;
	endfunction

	function automatic logic [COEF_W-1:0] coef_value(input coef_sel_t sel);
		logic [COEF_W-1:0] c;
		unique case (sel)
			COEF_SEL_MIN: c = COEF_MIN;
			COEF_SEL_SEC: c = COEF_SEC;
			default:      c = COEF_FRM;
		endcase
		return c;
	endfunction

	function automatic logic [BCD_W-1:0] bcd_value(input logic [7:0] b);
		logic [BCD_W-1:0] hi;
		logic [BCD_W-1:0] lo;
		hi = BCD_W'(b[7:4]);
		lo = BCD_W'(b[3:0]);
		return (hi << 3) + (hi << 1) + lo;
	endfunction

endpackage

>>> src/cdcpe_cmd_if.sv
// Interface: host access channel (command beats into the engine).
interface cdcpe_cmd_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] write_byte;
	logic [1:0] reg_select;

	modport source (output valid, output func, output write_byte, output reg_select,
		input ready);
	modport sink (input valid, input func, input write_byte, input reg_select,
		output ready);
endinterface

>>> src/cdcpe_rsp_if.sv
// Interface: result channel (one result beat per host access).
interface cdcpe_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  read_data;
	logic [2:0]                  engine_state;
	logic                        command_done;
	logic [cdcpe_pkg::ADDR_W-1:0] block_address;
	logic [7:0]                  block_count;

	modport source (output valid, output read_data, output engine_state,
		output command_done, output block_address, output block_count, input ready);
	modport sink (input valid, input read_data, input engine_state,
		input command_done, input block_address, input block_count, output ready);
endinterface

>>> src/cdcpe_top.sv
// Top level: CD-ROM command packet engine with packet store and address sequencer.
//
//  channel | dir | beat contents
//  cmd     | in  | func, write_byte, reg_select
//  rsp     | out | read_data, engine_state, command_done, block_address, block_count
//
// Register reads and writes that do not finish a read command: result registered, valid next cycle.
// A write that finishes a read command (0xC0): result after the address sequencer steps FETCH, MIN,
// SEC, FRM and FIN, feeding one multiply-accumulate unit from the packet store's single read port.
// cmd is not ready while the sequencer runs or while an untaken result blocks rsp.
// arst_n clears mode, counters, address, count and valid; no clearing pass.
module cdrom_command_packet_engine_top (
	input logic         clk,
	input logic         arst_n,
	cdcpe_cmd_if.sink   cmd,
	cdcpe_rsp_if.source rsp
);

	localparam int CNT_W = cdcpe_pkg::CNT_W;
	localparam int IDX_W = cdcpe_pkg::IDX_W;

	cdcpe_pkg::seq_state_t        seq_q, seq_n;
	cdcpe_pkg::mode_t             mode_q, run_mode;
	logic [CNT_W-1:0]             rcv_q, rcv_n;
	logic [cdcpe_pkg::LEN_W-1:0]  exp_q, exp_n;
	logic [cdcpe_pkg::ADDR_W-1:0] start_block_q;
	logic [7:0]                   count_q, count_n;
	logic [7:0]                   opcode_q, op_n;
	logic                         rsp_valid_q;

	logic                         accept, wr_acc, wr_new, done_n, go_read, load_rsp;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr, ram_raddr;
	logic [7:0]                   ram_rdata;
	cdcpe_pkg::addr_ctl_t         actl;
	logic [cdcpe_pkg::ADDR_W-1:0] blk;

	cdcpe_pkt_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.write_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cdcpe_addr_unit u_addr (
		.clk      (clk),
		.ctl      (actl),
		.bcd_byte (ram_rdata),
		.block    (blk)
	);

	assign accept = cmd.valid && cmd.ready;
	assign wr_acc = accept && !cmd.func;

	always_comb begin
		wr_new    = (mode_q != cdcpe_pkg::MODE_RECEIVE);
		op_n      = wr_new ? cmd.write_byte : opcode_q;
		ram_we    = 1'b0;
		ram_waddr = cdcpe_pkg::IDX_OPCODE;
		rcv_n     = rcv_q;
		exp_n     = exp_q;
		if (wr_new) begin
			ram_we = wr_acc;
			rcv_n  = CNT_W'(1);
			exp_n  = cdcpe_pkg::length_for(cmd.write_byte);
		end else if (rcv_q < CNT_W'(cdcpe_pkg::PACKET_BYTES)) begin
			ram_we    = wr_acc;
			ram_waddr = rcv_q[IDX_W-1:0];
			rcv_n     = rcv_q + CNT_W'(1);
		end
		done_n  = (rcv_n >= CNT_W'(exp_n));
		go_read = done_n && (op_n == cdcpe_pkg::OP_READ);
		if (!done_n) begin
			run_mode = cdcpe_pkg::MODE_RECEIVE;
		end else if (op_n == cdcpe_pkg::OP_XFER || op_n == cdcpe_pkg::OP_XFER2) begin
			run_mode = cdcpe_pkg::MODE_DATAOUT;
		end else if (go_read) begin
			run_mode = cdcpe_pkg::MODE_READ;
		end else begin
			run_mode = cdcpe_pkg::MODE_STATUS;
		end
		count_n = (ram_rdata == 8'd0) ? 8'd1 : ram_rdata;
	end

	always_comb begin
		seq_n = seq_q;
		unique case (seq_q)
			cdcpe_pkg::SEQ_IDLE: begin
				if (wr_acc && go_read) begin
					seq_n = cdcpe_pkg::SEQ_FETCH;
				end
			end
			cdcpe_pkg::SEQ_FETCH: seq_n = cdcpe_pkg::SEQ_MIN;
			cdcpe_pkg::SEQ_MIN:   seq_n = cdcpe_pkg::SEQ_SEC;
			cdcpe_pkg::SEQ_SEC:   seq_n = cdcpe_pkg::SEQ_FRM;
			cdcpe_pkg::SEQ_FRM:   seq_n = cdcpe_pkg::SEQ_FIN;
			cdcpe_pkg::SEQ_FIN:   seq_n = cdcpe_pkg::SEQ_IDLE;
			default:              seq_n = cdcpe_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready  = 1'b0;
		ram_raddr  = cdcpe_pkg::IDX_MIN;
		actl.load  = 1'b0;
		actl.accum = 1'b0;
		actl.coef  = cdcpe_pkg::COEF_SEL_MIN;
		unique case (seq_q)
			cdcpe_pkg::SEQ_IDLE: cmd.ready = !rsp_valid_q || rsp.ready;
			cdcpe_pkg::SEQ_FETCH: ram_raddr = cdcpe_pkg::IDX_MIN;
			cdcpe_pkg::SEQ_MIN: begin
				ram_raddr = cdcpe_pkg::IDX_SEC;
				actl.load = 1'b1;
			end
			cdcpe_pkg::SEQ_SEC: begin
				ram_raddr  = cdcpe_pkg::IDX_FRM;
				actl.accum = 1'b1;
				actl.coef  = cdcpe_pkg::COEF_SEL_SEC;
			end
			cdcpe_pkg::SEQ_FRM: begin
				ram_raddr  = cdcpe_pkg::IDX_COUNT;
				actl.accum = 1'b1;
				actl.coef  = cdcpe_pkg::COEF_SEL_FRM;
			end
			cdcpe_pkg::SEQ_FIN: ram_raddr = cdcpe_pkg::IDX_COUNT;
			default: cmd.ready = 1'b0;
		endcase
	end

	assign load_rsp = (accept && !(wr_acc && go_read)) || (seq_q == cdcpe_pkg::SEQ_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= cdcpe_pkg::SEQ_IDLE;
			mode_q        <= cdcpe_pkg::MODE_IDLE;
			rcv_q         <= '0;
			exp_q         <= '0;
			start_block_q <= '0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			seq_q <= seq_n;
			if (wr_acc) begin
				rcv_q <= rcv_n;
				exp_q <= exp_n;
				if (!go_read) begin
					mode_q <= run_mode;
				end
			end
			if (seq_q == cdcpe_pkg::SEQ_FIN) begin
				mode_q        <= cdcpe_pkg::MODE_READ;
				start_block_q <= blk;
				count_q       <= count_n;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_acc && wr_new) begin
			opcode_q <= cmd.write_byte;
		end
		if (seq_q == cdcpe_pkg::SEQ_FIN) begin
			rsp.read_data     <= 8'd0;
			rsp.engine_state  <= cdcpe_pkg::MODE_READ;
			rsp.command_done  <= 1'b1;
			rsp.block_address <= blk;
			rsp.block_count   <= count_n;
		end else if (accept && cmd.func) begin
			rsp.read_data     <= (cmd.reg_select == cdcpe_pkg::REG_STATUS) ?
				cdcpe_pkg::STATUS_VALUE : cdcpe_pkg::PHASE_VALUE;
			rsp.engine_state  <= mode_q;
			rsp.command_done  <= 1'b0;
			rsp.block_address <= start_block_q;
			rsp.block_count   <= count_q;
		end else if (wr_acc) begin
			rsp.read_data     <= 8'd0;
			rsp.engine_state  <= run_mode;
			rsp.command_done  <= done_n;
			rsp.block_address <= start_block_q;
			rsp.block_count   <= count_q;
		end
	end

	assign rsp.valid = rsp_valid_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != cdcpe_pkg::SEQ_IDLE |-> !cmd.ready)
		else $error("cmd ready while sequencer busy");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == cdcpe_pkg::SEQ_FIN |=> rsp.valid && rsp.command_done
			&& rsp.engine_state == cdcpe_pkg::MODE_READ)
		else $error("read command finished without result beat");

	a_regread_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func |=> rsp.valid && !rsp.command_done)
		else $error("register read reported command done");

	a_rcv_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == cdcpe_pkg::MODE_RECEIVE && seq_q == cdcpe_pkg::SEQ_IDLE
			|-> rcv_q < CNT_W'(exp_q))
		else $error("receiving with full packet");

endmodule

>>> src/cdcpe_pkt_ram.sv
// Packet store: one write port, one registered read port.
module cdcpe_pkt_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [cdcpe_pkg::IDX_W-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic [cdcpe_pkg::IDX_W-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [cdcpe_pkg::PACKET_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/cdcpe_addr_unit.sv
// Shared multiply-accumulate unit: BCD byte times coefficient into the block address.
module cdcpe_addr_unit (
	input  logic                         clk,
	input  cdcpe_pkg::addr_ctl_t         ctl,
	input  logic [7:0]                   bcd_byte,
	output logic [cdcpe_pkg::ADDR_W-1:0] block
);

	localparam int PROD_W = cdcpe_pkg::BCD_W + cdcpe_pkg::COEF_W;

	logic [cdcpe_pkg::ADDR_W-1:0] acc_q;
	logic [PROD_W-1:0]            prod;
	logic [cdcpe_pkg::ADDR_W-1:0] base;

	assign prod = PROD_W'(cdcpe_pkg::bcd_value(bcd_byte))
		* PROD_W'(cdcpe_pkg::coef_value(ctl.coef));
	assign base = ctl.load ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.accum) begin
			acc_q <= base + prod[cdcpe_pkg::ADDR_W-1:0];
		end
	end

	assign block = (acc_q >= cdcpe_pkg::LEAD_IN) ? acc_q - cdcpe_pkg::LEAD_IN : '0;

endmodule

>>> test/cdrom_command_packet_engine_top_test.sv
// Testbench for the CD-ROM command packet engine: random host traffic, checked against a predictor.
`timescale 1ns / 100ps

module cdrom_command_packet_engine_top_test;

	typedef struct packed {
		logic [7:0]                   read_data;
		cdcpe_pkg::mode_t             state;
		logic                         done;
		logic [cdcpe_pkg::ADDR_W-1:0] block_address;
		logic [7:0]                   block_count;
	} engine_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cdcpe_cmd_if cmd_bus();
	cdcpe_rsp_if rsp_bus();

	cdrom_command_packet_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the engine
	cdcpe_pkg::mode_t             sh_mode = cdcpe_pkg::MODE_IDLE;
	logic [7:0]                   sh_store [0:cdcpe_pkg::PACKET_BYTES-1];
	int                           sh_received = 0;
	int                           sh_expected = 0;
	logic [cdcpe_pkg::ADDR_W-1:0] sh_block = '0;
	logic [7:0]                   sh_count = '0;

	engine_result_t pending_results [$];

	int  errors = 0;
	int  accesses_sent = 0;
	int  results_checked = 0;
	int  reg_reads = 0;
	int  read_cmds = 0;
	int  dataout_cmds = 0;
	int  status_cmds = 0;
	int  clamped_reads = 0;
	bit  no_gaps = 1'b0;
	int  hold_request = 0;

	function automatic int opcode_length(input logic [7:0] op);
		case (op)
			cdcpe_pkg::OP_SEEK, cdcpe_pkg::OP_EXT: return 2;
			cdcpe_pkg::OP_PARAM:                   return 3;
			cdcpe_pkg::OP_READ:                    return 7;
			default:                               return 1;
		endcase
	endfunction

	function automatic int bcd_to_int(input logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic [7:0] random_bcd();
		logic [3:0] hi;
		logic [3:0] lo;
		hi = 4'($urandom_range(9));
		lo = 4'($urandom_range(9));
		return {hi, lo};
	endfunction

	task automatic predict_engine_result(input logic f, input logic [7:0] b,
		input logic [1:0] s, output engine_result_t r);
		int frames;
		int i;
		r.read_data = '0;
		r.done = 1'b0;
		if (f) begin
			r.read_data = (s == cdcpe_pkg::REG_STATUS) ?
				cdcpe_pkg::STATUS_VALUE : cdcpe_pkg::PHASE_VALUE;
			reg_reads++;
		end else begin
			if (sh_mode != cdcpe_pkg::MODE_RECEIVE) begin
				for (i = 0; i < cdcpe_pkg::PACKET_BYTES; i++)
					sh_store[i] = '0;
				sh_store[cdcpe_pkg::IDX_OPCODE] = b;
				sh_received = 1;
				sh_expected = opcode_length(b);
				sh_mode = cdcpe_pkg::MODE_RECEIVE;
			end else if (sh_received < cdcpe_pkg::PACKET_BYTES) begin
				sh_store[sh_received] = b;
				sh_received++;
			end
			if (sh_received >= sh_expected) begin
				r.done = 1'b1;
				case (sh_store[cdcpe_pkg::IDX_OPCODE])
					cdcpe_pkg::OP_XFER, cdcpe_pkg::OP_XFER2: begin
						sh_mode = cdcpe_pkg::MODE_DATAOUT;
						dataout_cmds++;
					end
					cdcpe_pkg::OP_READ: begin
						frames = bcd_to_int(sh_store[cdcpe_pkg::IDX_MIN]) * 60 * 75
							+ bcd_to_int(sh_store[cdcpe_pkg::IDX_SEC]) * 75
							+ bcd_to_int(sh_store[cdcpe_pkg::IDX_FRM]);
						if (frames >= 150) begin
							sh_block = cdcpe_pkg::ADDR_W'(frames - 150);
						end else begin
							sh_block = '0;
							clamped_reads++;
						end
						sh_count = (sh_store[cdcpe_pkg::IDX_COUNT] == 8'd0) ?
							8'd1 : sh_store[cdcpe_pkg::IDX_COUNT];
						sh_mode = cdcpe_pkg::MODE_READ;
						read_cmds++;
					end
					default: begin
						sh_mode = cdcpe_pkg::MODE_STATUS;
						status_cmds++;
					end
				endcase
			end
		end
		r.state = sh_mode;
		r.block_address = sh_block;
		r.block_count = sh_count;
	endtask

	task automatic send_access(input logic f, input logic [7:0] b, input logic [1:0] s);
		engine_result_t r;
		if (!no_gaps && $urandom_range(99) < 6) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= f;
		cmd_bus.write_byte <= b;
		cmd_bus.reg_select <= s;
		do @(posedge clk); while (!cmd_bus.ready);
		predict_engine_result(f, b, s, r);
		pending_results.push_back(r);
		accesses_sent++;
	endtask

	task automatic host_write(input logic [7:0] b);
		send_access(1'b0, b, 2'($urandom_range(3)));
	endtask

	task automatic host_read(input logic [1:0] s);
		send_access(1'b1, 8'($urandom_range(255)), s);
	endtask

	task automatic release_bus();
		cmd_bus.valid <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// one well-formed packet, register reads sprinkled in between its bytes
	task automatic send_packet(input logic [7:0] op);
		logic [7:0] body [0:cdcpe_pkg::PACKET_BYTES-1];
		int i;
		for (i = 0; i < cdcpe_pkg::PACKET_BYTES; i++)
			body[i] = 8'($urandom_range(255));
		if (op == cdcpe_pkg::OP_READ) begin
			if ($urandom_range(99) < 70) begin
				body[cdcpe_pkg::IDX_MIN] = random_bcd();
				body[cdcpe_pkg::IDX_SEC] = random_bcd();
				body[cdcpe_pkg::IDX_FRM] = random_bcd();
			end
			if ($urandom_range(99) < 15) begin
				body[cdcpe_pkg::IDX_MIN] = 8'h00;
				body[cdcpe_pkg::IDX_SEC] = {4'h0, 4'($urandom_range(2))};
				body[cdcpe_pkg::IDX_FRM] = random_bcd();
			end
			if ($urandom_range(99) < 20)
				body[cdcpe_pkg::IDX_COUNT] = 8'h00;
		end
		host_write(op);
		for (i = 1; i < opcode_length(op); i++) begin
			if ($urandom_range(99) < 10)
				host_read(2'($urandom_range(3)));
			host_write(body[i]);
		end
	endtask

	task automatic send_random_traffic_item();
		int pick;
		logic [7:0] ops [0:6];
		ops = '{cdcpe_pkg::OP_SEEK, cdcpe_pkg::OP_GETINFO, cdcpe_pkg::OP_PARAM,
			cdcpe_pkg::OP_XFER, cdcpe_pkg::OP_XFER2, cdcpe_pkg::OP_EXT, 8'h00};
		pick = $urandom_range(99);
		if (pick < 8) begin
			host_write(8'($urandom_range(255)));
		end else if (pick < 18) begin
			host_read(2'($urandom_range(3)));
		end else if (pick < 52) begin
			send_packet(cdcpe_pkg::OP_READ);
		end else begin
			ops[6] = 8'($urandom_range(255));
			send_packet(ops[$urandom_range(6)]);
		end
	endtask

	task automatic test_register_reads();
		int s;
		for (s = 0; s < 4; s++)
			host_read(2'(s));
	endtask

	task automatic test_short_commands();
		host_write(cdcpe_pkg::OP_GETINFO);
		host_write(cdcpe_pkg::OP_XFER);
		host_write(cdcpe_pkg::OP_XFER2);
		host_write(8'h00);
		host_write(8'hFF);
		host_write(cdcpe_pkg::OP_SEEK);
		host_write(8'h00);
		host_write(cdcpe_pkg::OP_PARAM);
		host_write(8'hFF);
		host_write(8'h55);
		host_write(cdcpe_pkg::OP_EXT);
		host_write(8'hAA);
	endtask

	task automatic test_read_command();
		// largest non-BCD address, zero count, status read mid-packet
		host_write(cdcpe_pkg::OP_READ);
		host_write(8'hFF);
		host_write(8'hFF);
		host_read(cdcpe_pkg::REG_STATUS);
		host_write(8'hFF);
		host_write(8'hAA);
		host_write(8'h55);
		host_write(8'h00);
		// 00:01:74 lies inside the lead-in, address clamps to zero
		host_write(cdcpe_pkg::OP_READ);
		host_write(8'h00);
		host_write(8'h01);
		host_write(8'h74);
		host_write(8'h00);
		host_write(8'h00);
		host_write(8'hFF);
	endtask

	task automatic test_backpressure();
		int start;
		start = accesses_sent;
		no_gaps = 1'b1;
		hold_request = 80;
		while (accesses_sent - start < 40)
			send_random_traffic_item();
		no_gaps = 1'b0;
	endtask

	task automatic test_drain_pause();
		int start;
		start = accesses_sent;
		while (accesses_sent - start < 20)
			send_random_traffic_item();
		release_bus();
		wait_until_drained();
		repeat (8) @(posedge clk);
		while (accesses_sent - start < 40)
			send_random_traffic_item();
	endtask

	task automatic test_random_traffic(input int count);
		int start;
		start = accesses_sent;
		while (accesses_sent - start < count) begin
			no_gaps = (accesses_sent - start >= 300) && (accesses_sent - start < 450);
			send_random_traffic_item();
		end
		no_gaps = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		engine_result_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, actual state %0d data 0x%0h",
					$time, rsp_bus.engine_state, rsp_bus.read_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", 32'(want.read_data), 32'(rsp_bus.read_data));
				check_field("engine_state", 32'(want.state), 32'(rsp_bus.engine_state));
				check_field("command_done", 32'(want.done), 32'(rsp_bus.command_done));
				check_field("block_address", 32'(want.block_address),
					32'(rsp_bus.block_address));
				check_field("block_count", 32'(want.block_count), 32'(rsp_bus.block_count));
				results_checked++;
			end
		end
	end

	// result sink: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= no_gaps || ($urandom_range(99) >= 6);
			end
		end
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		cmd_bus.valid <= 1'b0;
		cmd_bus.func <= 1'b0;
		cmd_bus.write_byte <= 8'h00;
		cmd_bus.reg_select <= 2'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reads();
		test_short_commands();
		test_read_command();
		test_backpressure();
		test_drain_pause();
		test_random_traffic(720);

		release_bus();
		wait_until_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d host accesses, %0d results checked, %0d register reads",
			accesses_sent, results_checked, reg_reads);
		$display("Packets: %0d read (%0d clamped to block 0), %0d data-out, %0d status",
			read_cmds, clamped_reads, dataout_cmds, status_cmds);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
